// ===== hw/rtl/cave_automaton_step_macros.svh =====
// Assertion helpers for the cave automaton block.
`ifndef CAVE_AUTOMATON_STEP_MACROS_SVH
`define CAVE_AUTOMATON_STEP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define CAS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cave_automaton_step: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cave_automaton_step: check failed");

`else

`define CAS_ASSERT_IMPL(lbl, ante, cons)
`define CAS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/cas_pkg.sv =====
package cas_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int STATE_W = 2;
	localparam int SIZE_W  = 9;
	localparam int DLIM_W  = 4;
	localparam int BLIM_W  = 4;
	localparam int WLIM_W  = 3;
	localparam int COORD_W = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int LS_W    = 2 * STATE_W;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [STATE_W-1:0] cell_t;

	localparam cell_t CELL_DEAD  = 2'd0;
	localparam cell_t CELL_ALIVE = 2'd1;
	localparam cell_t CELL_WALL  = 2'd2;

	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RULE_MODE   = 3'd2;
	localparam logic [2:0] REG_DEATH_LIMIT = 3'd3;
	localparam logic [2:0] REG_BIRTH_LIMIT = 3'd4;
	localparam logic [2:0] REG_WALL_LIMIT  = 3'd5;

	localparam logic [SIZE_W-1:0] RST_GRID_WIDTH  = 9'd64;
	localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT = 9'd64;
	localparam logic              RST_RULE_MODE   = 1'b0;
	localparam logic [DLIM_W-1:0] RST_DEATH_LIMIT = 4'd3;
	localparam logic [BLIM_W-1:0] RST_BIRTH_LIMIT = 4'd4;
	localparam logic [WLIM_W-1:0] RST_WALL_LIMIT  = 3'd4;

	localparam logic MODE_MOORE = 1'b0;

	typedef struct packed {
		logic [SIZE_W-1:0] grid_width;
		logic [SIZE_W-1:0] grid_height;
		logic              rule_mode;
		logic [DLIM_W-1:0] death_limit;
		logic [BLIM_W-1:0] birth_limit;
		logic [WLIM_W-1:0] wall_limit;
	} cfg_t;

	// one grid column entering the window, plus what to emit when it does
	typedef struct packed {
		cell_t              top;
		cell_t              mid;
		cell_t              bot;
		logic               first;
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} col_t;

	typedef struct packed {
		logic clearing;
		logic s1_valid;
	} fe_status_t;

endpackage

// ===== hw/rtl/cave_automaton_step.sv =====
// Cave-smoothing cellular automaton, one generation per pass over a grid sent in raster
// order, one cell per item. The block takes one item per clock while out_stall is low;
// the next state of a cell comes out when the cell one row and one column past it has
// gone in, through the stage-1 register, queue and output register, and the host follows
// the grid with grid_width + 1 pad items to flush the tail. A single line store (two rows
// packed per word, one read and one write per cycle) sets that rate. After reset the line
// store is cleared while in_stall is high; register writes are taken as usual.
`include "cave_automaton_step_macros.svh"

module cave_automaton_step import cas_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,

	input  logic               in_valid,
	output logic               in_stall,
	input  cell_t              cell_state,
	input  logic               pad,

	output logic               out_valid,
	input  logic               out_stall,
	output cell_t              next_state,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic               last_cell
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;

	col_t       fe_col;
	col_t       be_col;
	logic       q_push;
	logic       q_ready;
	logic       q_pop;
	logic       q_nonempty;
	fe_status_t fe_status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= RST_GRID_WIDTH;
			cfg_q.grid_height <= RST_GRID_HEIGHT;
			cfg_q.rule_mode   <= RST_RULE_MODE;
			cfg_q.death_limit <= RST_DEATH_LIMIT;
			cfg_q.birth_limit <= RST_BIRTH_LIMIT;
			cfg_q.wall_limit  <= RST_WALL_LIMIT;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[SIZE_W-1:0];
				REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[SIZE_W-1:0];
				REG_RULE_MODE:   cfg_q.rule_mode   <= pwdata[0];
				REG_DEATH_LIMIT: cfg_q.death_limit <= pwdata[DLIM_W-1:0];
				REG_BIRTH_LIMIT: cfg_q.birth_limit <= pwdata[BLIM_W-1:0];
				REG_WALL_LIMIT:  cfg_q.wall_limit  <= pwdata[WLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRID_WIDTH:  prdata = DATA_W'(cfg_q.grid_width);
			REG_GRID_HEIGHT: prdata = DATA_W'(cfg_q.grid_height);
			REG_RULE_MODE:   prdata = DATA_W'(cfg_q.rule_mode);
			REG_DEATH_LIMIT: prdata = DATA_W'(cfg_q.death_limit);
			REG_BIRTH_LIMIT: prdata = DATA_W'(cfg_q.birth_limit);
			REG_WALL_LIMIT:  prdata = DATA_W'(cfg_q.wall_limit);
			default:         prdata = '0;
		endcase
	end

	cas_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_state (cell_state),
		.pad        (pad),
		.q_ready    (q_ready),
		.q_push     (q_push),
		.q_data     (fe_col),
		.status     (fe_status)
	);

	cas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (fe_col),
		.ready    (q_ready),
		.pop      (q_pop),
		.rdata    (be_col),
		.nonempty (q_nonempty)
	);

	cas_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_nonempty),
		.q_data     (be_col),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.next_state (next_state),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_cell  (last_cell)
	);

	`CAS_ASSERT_IMPL(a_no_accept_clearing, in_valid && !in_stall, !fe_status.clearing)
	`CAS_ASSERT_IMPL(a_stall_on_full, fe_status.s1_valid && !q_ready, in_stall)
	`CAS_ASSERT_IMPL(a_pop_nonempty, q_pop, q_nonempty)
	`CAS_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_nonempty)

endmodule

// ===== hw/rtl/cas_ram.sv =====
module cas_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/cas_queue.sv =====
module cas_queue import cas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  col_t wdata,
	output logic ready,
	input  logic pop,
	output col_t rdata,
	output logic nonempty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	col_t            ent_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign ready    = (count_q != NW'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/cas_front.sv =====
module cas_front import cas_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  cell_t      cell_state,
	input  logic       pad,
	input  logic       q_ready,
	output logic       q_push,
	output col_t       q_data,
	output fe_status_t status
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int LW  = (WW > SIZE_W) ? WW : SIZE_W;
	localparam int LH  = (HW > SIZE_W) ? HW : SIZE_W;
	localparam int CXW = (WW > COORD_W) ? WW : COORD_W;
	localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

	// position of the next item
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;

	// line store clearing pass
	logic          clearing_q;
	logic [CW-1:0] clr_q;

	// stage 1: item waiting for its line store read
	logic               s1_valid_q;
	cell_t              v_s1;
	logic [CW-1:0]      ci_s1;
	logic               a_ok_s1;
	logic               b_ok_s1;
	logic               first_s1;
	logic               emit_s1;
	logic               last_s1;
	logic [COORD_W-1:0] row_s1;
	logic [COORD_W-1:0] col_s1;
	logic               fwd_s1;
	logic [LS_W-1:0]    fwd_data_s1;

	logic [LW-1:0]      w_ext;
	logic [LH-1:0]      h_ext;
	logic [WW-1:0]      w;
	logic [HW-1:0]      h;
	logic [RW-1:0]      h1;
	logic               restart;
	logic [RW-1:0]      ri;
	logic [CW-1:0]      ci;
	logic [WW-1:0]      ci_inc;
	logic [RW-1:0]      nxt_row;
	logic [CW-1:0]      nxt_col;
	cell_t              v;
	logic               first;
	logic [RXW-1:0]     row_calc;
	logic [CXW-1:0]     col_calc;

	logic               accept;
	logic               s1_adv;
	logic [LS_W-1:0]    ram_rdata;
	logic [LS_W-1:0]    rd_word;
	logic [LS_W-1:0]    wr_word;
	cell_t              a_s1;
	cell_t              b_s1;
	logic               ram_we;
	logic [CW-1:0]      ram_waddr;
	logic [LS_W-1:0]    ram_wdata;

	always_comb begin
		w_ext = LW'(cfg.grid_width);
		h_ext = LH'(cfg.grid_height);
		if (w_ext == '0) begin
			w = WW'(1);
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(w_ext);
		end
		if (h_ext == '0) begin
			h = HW'(1);
		end else if (h_ext > LH'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(h_ext);
		end
		h1 = RW'(h) + RW'(1);

		restart = (WW'(in_col_q) >= w) || (in_row_q > h1) ||
			((in_row_q == h1) && (in_col_q != '0));
		ri = restart ? '0 : in_row_q;
		ci = restart ? '0 : in_col_q;

		v = (pad || (ri >= RW'(h))) ? CELL_DEAD : cell_state;

		ci_inc = WW'(ci) + WW'(1);
		if (ri == h1) begin
			nxt_row = '0;
			nxt_col = '0;
		end else if (ci_inc >= w) begin
			nxt_row = ri + RW'(1);
			nxt_col = '0;
		end else begin
			nxt_row = ri;
			nxt_col = CW'(ci_inc);
		end

		first    = (ci == '0);
		row_calc = RXW'(ri) - (first ? RXW'(2) : RXW'(1));
		col_calc = first ? (CXW'(w) - CXW'(1)) : (CXW'(ci) - CXW'(1));
	end

	assign s1_adv   = s1_valid_q && q_ready;
	assign in_stall = clearing_q || (s1_valid_q && !q_ready);
	assign accept   = in_valid && !in_stall;

	assign rd_word = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign a_s1    = a_ok_s1 ? rd_word[LS_W-1:STATE_W] : CELL_DEAD;
	assign b_s1    = b_ok_s1 ? rd_word[STATE_W-1:0] : CELL_DEAD;
	assign wr_word = {v_s1, a_s1};

	assign ram_we    = clearing_q || s1_adv;
	assign ram_waddr = clearing_q ? clr_q : ci_s1;
	assign ram_wdata = clearing_q ? '0 : wr_word;

	cas_ram #(
		.WIDTH (LS_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ci),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + CW'(1);
				if (clr_q == CW'(MAX_WIDTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				in_row_q   <= nxt_row;
				in_col_q   <= nxt_col;
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1        <= v;
			ci_s1       <= ci;
			a_ok_s1     <= (ri >= RW'(1));
			b_ok_s1     <= (ri >= RW'(2));
			first_s1    <= first;
			emit_s1     <= first ? (ri >= RW'(2)) : (ri >= RW'(1));
			last_s1     <= (ri == h1);
			row_s1      <= row_calc[COORD_W-1:0];
			col_s1      <= col_calc[COORD_W-1:0];
			// same column written by the item ahead in this very cycle
			fwd_s1      <= s1_adv && (ci_s1 == ci);
			fwd_data_s1 <= wr_word;
		end
	end

	assign q_push       = s1_adv;
	assign q_data.top   = b_s1;
	assign q_data.mid   = a_s1;
	assign q_data.bot   = v_s1;
	assign q_data.first = first_s1;
	assign q_data.emit  = emit_s1;
	assign q_data.last  = last_s1;
	assign q_data.row   = row_s1;
	assign q_data.col   = col_s1;

	assign status.clearing = clearing_q;
	assign status.s1_valid = s1_valid_q;

endmodule

// ===== hw/rtl/cas_back.sv =====
module cas_back import cas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  col_t               q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output cell_t              next_state,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic               last_cell
);

	// [col][row], col 0 left, row 0 top
	cell_t [2:0][2:0] win_q;
	cell_t [2:0][2:0] sh;
	cell_t [2:0]      new_col;

	logic               out_valid_q;
	cell_t              next_state_q;
	logic [COORD_W-1:0] out_row_q;
	logic [COORD_W-1:0] out_col_q;
	logic               last_cell_q;

	cell_t       ctr;
	logic [3:0]  n8;
	logic [2:0]  n4;
	cell_t       nxt;

	function automatic logic al(input cell_t c);
		return (c == CELL_ALIVE);
	endfunction

	assign new_col[0] = q_data.top;
	assign new_col[1] = q_data.mid;
	assign new_col[2] = q_data.bot;

	always_comb begin
		sh[0] = win_q[1];
		sh[1] = win_q[2];
		sh[2] = q_data.first ? '0 : new_col;
		ctr   = sh[1][1];
		n4 = 3'(al(sh[1][0])) + 3'(al(sh[0][1])) + 3'(al(sh[2][1])) + 3'(al(sh[1][2]));
		n8 = 4'(n4) + 4'(al(sh[0][0])) + 4'(al(sh[0][2])) +
			4'(al(sh[2][0])) + 4'(al(sh[2][2]));
		nxt = ctr;
		if (cfg.rule_mode == MODE_MOORE) begin
			if (ctr == CELL_ALIVE && n8 < cfg.death_limit) begin
				nxt = CELL_DEAD;
			end else if (ctr == CELL_DEAD && n8 > cfg.birth_limit) begin
				nxt = CELL_ALIVE;
			end
		end else begin
			if (ctr == CELL_ALIVE && n4 < cfg.wall_limit) begin
				nxt = CELL_WALL;
			end
		end
	end

	assign q_pop = q_valid && (!q_data.emit || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				win_q[0] <= q_data.first ? '0 : win_q[1];
				win_q[1] <= q_data.first ? '0 : win_q[2];
				win_q[2] <= new_col;
			end
			if (q_pop && q_data.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.emit) begin
			next_state_q <= nxt;
			out_row_q    <= q_data.row;
			out_col_q    <= q_data.col;
			last_cell_q  <= q_data.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_state = next_state_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign last_cell  = last_cell_q;

endmodule
